FILE: sv/scalar_kalman_filter_core_defines.svh
// Assertion macros shared by the scalar Kalman filter RTL.
`ifndef SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define SKF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define SKF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/skf_pkg.sv
// Types and constants of the scalar Kalman filter.
package skf_pkg;

	localparam int MEAS_W   = 16;
	localparam int EST_W    = 24;
	localparam int GAIN_W   = 17;
	localparam int VAR_W    = 32;
	localparam int SUM_W    = VAR_W + 1;
	localparam int DIFF_W   = EST_W + 1;
	localparam int FRAC_W   = 16;
	localparam int PRODE_W  = DIFF_W + GAIN_W;
	localparam int PRODV_W  = VAR_W + GAIN_W;
	localparam int CNT_W    = 5;
	localparam int CFG_IDX_W = 8;
	localparam int OUT_W    = 80;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
	localparam logic [CNT_W-1:0] GAIN_STEPS = CNT_W'(GAIN_W);
	localparam logic [VAR_W-1:0] ERR_RESET = VAR_W'(65536);

	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_ERROR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ERROR = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} skf_state_t;

endpackage

FILE: sv/skf_div.sv
// Radix-2 restoring divider producing the 17-bit Q0.16 gain, one bit per cycle.
module skf_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [skf_pkg::VAR_W-1:0]         dividend,
	input  logic [skf_pkg::SUM_W-1:0]         divisor,
	output logic                              done,
	output logic [skf_pkg::GAIN_W-1:0]        quotient
);

	logic                             busy_q;
	logic [skf_pkg::CNT_W-1:0]        cnt_q;
	logic [skf_pkg::SUM_W:0]          rem_q;
	logic [skf_pkg::SUM_W-1:0]        div_q;
	logic [skf_pkg::GAIN_W-1:0]       quo_q;
	logic                             ge;
	logic [skf_pkg::SUM_W:0]          trial;
	logic [skf_pkg::SUM_W-1:0]        rem_sel;

	assign trial   = rem_q - {1'b0, div_q};
	assign ge      = (rem_q >= {1'b0, div_q});
	assign rem_sel = ge ? trial[skf_pkg::SUM_W-1:0] : rem_q[skf_pkg::SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= skf_pkg::GAIN_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == skf_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {2'b00, dividend};
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_sel, 1'b0};
			quo_q <= {quo_q[skf_pkg::GAIN_W-2:0], ge};
		end
	end

	assign quotient = quo_q;

endmodule

FILE: sv/scalar_kalman_filter_core.sv
// Scalar Kalman filter: one request per measurement yields one request carrying the new
// estimate, the gain and the new variance. An item passes from acceptance to result
// through a load step, the bit-serial gain divider, two shift-and-add multipliers that
// step side by side through the bits of the gain and of one minus the gain, and a commit
// step. The next measurement is accepted once the previous one has committed,
// even while its result still waits at the output register.
module scalar_kalman_filter_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [skf_pkg::MEAS_W-1:0]            s_tdata,   // [15:0] measurement
	input  logic [0:0]                            s_tuser,   // [0] restart
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [skf_pkg::OUT_W-1:0]             m_tdata,   // [23:0] estimate, [40:24] gain,
	                                                         // [72:41] variance, [79:73] zero
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [skf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [skf_pkg::VAR_W-1:0]             cfg_data
);

	skf_pkg::skf_state_t                 state_q, state_d;
	logic [skf_pkg::VAR_W-1:0]           meas_err_q;
	logic [skf_pkg::VAR_W-1:0]           init_err_q;
	logic [skf_pkg::EST_W-1:0]           est_q;
	logic [skf_pkg::VAR_W-1:0]           var_q;
	logic [skf_pkg::VAR_W-1:0]           var_work_q;
	logic [skf_pkg::DIFF_W-1:0]          diff_q;
	logic                                sum_zero_q;
	logic [skf_pkg::GAIN_W-1:0]          gain_q;
	logic [skf_pkg::GAIN_W-1:0]          gbits_q;
	logic [skf_pkg::GAIN_W-1:0]          hbits_q;
	logic [skf_pkg::PRODE_W-1:0]         mcand_e_q;
	logic [skf_pkg::PRODE_W-1:0]         acc_e_q;
	logic [skf_pkg::PRODV_W-1:0]         mcand_v_q;
	logic [skf_pkg::PRODV_W-1:0]         acc_v_q;
	logic [skf_pkg::CNT_W-1:0]           cnt_q;
	logic [skf_pkg::EST_W-1:0]           est_out_q;
	logic [skf_pkg::GAIN_W-1:0]          gain_out_q;
	logic [skf_pkg::VAR_W-1:0]           var_out_q;
	logic                                out_valid_q;

	logic                                in_accept;
	logic                                out_load;
	logic                                div_done;
	logic [skf_pkg::GAIN_W-1:0]          div_quo;
	logic [skf_pkg::VAR_W-1:0]           var_start;
	logic [skf_pkg::SUM_W-1:0]           sum_start;
	logic [skf_pkg::DIFF_W-1:0]          diff_start;
	logic [skf_pkg::GAIN_W-1:0]          gain_sel;
	logic [skf_pkg::EST_W-1:0]           est_new;
	logic [skf_pkg::VAR_W-1:0]           var_new;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_err_q <= skf_pkg::ERR_RESET;
			init_err_q <= skf_pkg::ERR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == skf_pkg::REG_MEASURE_ERROR) begin
				meas_err_q <= cfg_data;
			end else if (cfg_index == skf_pkg::REG_INITIAL_ERROR) begin
				init_err_q <= cfg_data;
			end
		end
	end

	assign var_start  = s_tuser[0] ? init_err_q : var_q;
	assign sum_start  = {1'b0, var_start} + {1'b0, meas_err_q};
	assign diff_start = {s_tdata[skf_pkg::MEAS_W-1], s_tdata, 8'h00}
	                  - {est_q[skf_pkg::EST_W-1], est_q};

	skf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_accept),
		.dividend (var_start),
		.divisor  (sum_start),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign gain_sel = sum_zero_q ? '0 : div_quo;
	assign est_new  = est_q + acc_e_q[skf_pkg::FRAC_W +: skf_pkg::EST_W];
	assign var_new  = acc_v_q[skf_pkg::FRAC_W +: skf_pkg::VAR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			skf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = skf_pkg::ST_DIV;
				end
			end
			skf_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = skf_pkg::ST_MUL;
				end
			end
			skf_pkg::ST_MUL: begin
				if (cnt_q == skf_pkg::CNT_W'(1)) begin
					state_d = skf_pkg::ST_DONE;
				end
			end
			skf_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = skf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = skf_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q       <= '0;
			var_q       <= skf_pkg::ERR_RESET;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_load) begin
				est_q       <= est_new;
				var_q       <= var_new;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == skf_pkg::ST_DIV && div_done) begin
				cnt_q <= skf_pkg::GAIN_STEPS;
			end else if (state_q == skf_pkg::ST_MUL) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			var_work_q <= var_start;
			diff_q     <= diff_start;
			sum_zero_q <= (sum_start == '0);
		end
		if (state_q == skf_pkg::ST_DIV && div_done) begin
			gain_q    <= gain_sel;
			gbits_q   <= gain_sel;
			hbits_q   <= skf_pkg::GAIN_ONE - gain_sel;
			mcand_e_q <= {{skf_pkg::GAIN_W{diff_q[skf_pkg::DIFF_W-1]}}, diff_q};
			mcand_v_q <= {{skf_pkg::GAIN_W{1'b0}}, var_work_q};
			acc_e_q   <= '0;
			acc_v_q   <= '0;
		end else if (state_q == skf_pkg::ST_MUL) begin
			if (gbits_q[0]) begin
				acc_e_q <= acc_e_q + mcand_e_q;
			end
			if (hbits_q[0]) begin
				acc_v_q <= acc_v_q + mcand_v_q;
			end
			mcand_e_q <= {mcand_e_q[skf_pkg::PRODE_W-2:0], 1'b0};
			mcand_v_q <= {mcand_v_q[skf_pkg::PRODV_W-2:0], 1'b0};
			gbits_q   <= {1'b0, gbits_q[skf_pkg::GAIN_W-1:1]};
			hbits_q   <= {1'b0, hbits_q[skf_pkg::GAIN_W-1:1]};
		end
		if (out_load) begin
			est_out_q  <= est_new;
			gain_out_q <= gain_q;
			var_out_q  <= var_new;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, var_out_q, gain_out_q, est_out_q};

`include "scalar_kalman_filter_core_defines.svh"

	`SKF_ASSERT_IMP(a_gain_bound, m_tvalid, gain_out_q <= skf_pkg::GAIN_ONE, "gain above one")
	`SKF_ASSERT_IMP(a_var_shrinks, state_q == skf_pkg::ST_DONE, var_new <= var_work_q, "variance grew")
	`SKF_ASSERT_IMP(a_zero_sum_gain, state_q == skf_pkg::ST_DONE && sum_zero_q, gain_q == '0, "gain nonzero on zero sum")
	`SKF_ASSERT_NXT(a_commit, out_load, m_tvalid && state_q == skf_pkg::ST_IDLE, "result not committed")

endmodule
